[rtl/core/hashed_weighted_pick_with_jitter_top_macros.svh]
// ----------------------------------------------------------------------------
// hashed_weighted_pick_with_jitter_top_macros
// Assertion macros for the weighted picker checker.
// ----------------------------------------------------------------------------
`ifndef HASHED_WEIGHTED_PICK_WITH_JITTER_TOP_MACROS_SVH
`define HASHED_WEIGHTED_PICK_WITH_JITTER_TOP_MACROS_SVH
// Same-cycle implication, sampled on clk, off during reset.
`define HWP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define HWP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/core/hwp_pkg.sv]
// ----------------------------------------------------------------------------
// hwp_pkg
// Types and constants of the hashed weighted picker.
// ----------------------------------------------------------------------------
`default_nettype none
package hwp_pkg;
	localparam logic [63:0] GOLDEN  = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [18:0] TOTAL_MAX = 19'h7FFFF;

	typedef enum logic [1:0] {
		OP_QUERY  = 2'd0,
		OP_APPEND = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_PICKED   = 3'd0,
		ST_APPENDED = 3'd1,
		ST_REJECTED = 3'd2,
		ST_NONE     = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_PICK_SEED   = 3'd0,
		REG_OFFSET_SEED = 3'd1,
		REG_JITTER      = 3'd2,
		REG_SELECTOR    = 3'd3,
		REG_RESOLUTION  = 3'd4,
		REG_MODE        = 3'd5
	} reg_idx_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MIX   = 6'b000010,
		S_FMIX  = 6'b000100,
		S_MULHI = 6'b001000,
		S_SCAN  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PASS_PICK = 2'd0,
		PASS_JX   = 2'd1,
		PASS_JZ   = 2'd2
	} pass_t;
endpackage
`default_nettype wire

[rtl/core/hashed_weighted_pick_with_jitter_top.sv]
// ----------------------------------------------------------------------------
// hashed_weighted_pick_with_jitter_top
// Hash-based weighted candidate picker with per-axis position jitter.
// ----------------------------------------------------------------------------
// Append and clear transfers finish in the cycle they are taken and their
// result shows in the cycle after. A query runs on one shared 32x32
// multiplier and one 64-bit combine/xor path under a small sequencer: the
// pick hash (5 combines, 9 fmix steps, 2 scaling steps), then a scan of the
// table, one entry per cycle, then, when jitter_limit is nonzero, the x
// jitter chain (4 combines, 9 fmix steps, 2 scaling steps) and the z chain
// (1 more combine, 9 fmix steps, 2 scaling steps), then an output state.
// The scan stops at the chosen entry, so a query takes longer the later
// that entry sits in the table (scan position 1..MAX_CANDIDATES). The
// sequencer returns to idle as the result is written. The input is not
// ready while a query runs, nor while a result waits in the output register
// unless out_ready takes it in that same cycle. The candidate table has no
// reset: only entries below the fill count are read.
`default_nettype none
module hashed_weighted_pick_with_jitter_top
	import hwp_pkg::*;
#(
	parameter int MAX_CANDIDATES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic signed [23:0] cell_x,
	input  wire logic signed [23:0] cell_z,
	input  wire logic signed [23:0] anchor_x,
	input  wire logic signed [23:0] anchor_z,
	input  wire logic [15:0] entry_weight,
	input  wire logic        entry_empty,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [2:0]       chosen_index,
	output logic             spawn_flag,
	output logic signed [24:0] place_x,
	output logic signed [24:0] place_z
);
	localparam int IDXW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CNTW = $clog2(MAX_CANDIDATES + 1);
	localparam int SCW  = (IDXW > 4) ? IDXW : 4;
	localparam int CMPW = ((SCW > CNTW) ? SCW : CNTW) + 1;

	// config registers
	logic [63:0] pick_seed_q, offset_seed_q;
	logic [11:0] jitter_q;
	logic [31:0] selector_q;
	logic [4:0]  resolution_q;
	logic        mode_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pick_seed_q   <= '0;
			offset_seed_q <= '0;
			jitter_q      <= '0;
			selector_q    <= 32'd1;
			resolution_q  <= '0;
			mode_q        <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_PICK_SEED:   pick_seed_q   <= pwdata;
				REG_OFFSET_SEED: offset_seed_q <= pwdata;
				REG_JITTER:      jitter_q      <= pwdata[11:0];
				REG_SELECTOR:    selector_q    <= pwdata[31:0];
				REG_RESOLUTION:  resolution_q  <= pwdata[4:0];
				REG_MODE:        mode_q        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_PICK_SEED:   prdata = pick_seed_q;
			REG_OFFSET_SEED: prdata = offset_seed_q;
			REG_JITTER:      prdata = {52'd0, jitter_q};
			REG_SELECTOR:    prdata = {32'd0, selector_q};
			REG_RESOLUTION:  prdata = {59'd0, resolution_q};
			REG_MODE:        prdata = {63'd0, mode_q};
			default:         prdata = '0;
		endcase
	end

	// candidate table: running sums and empty marks
	logic [18:0] rw_q [MAX_CANDIDATES];
	logic        em_q [MAX_CANDIDATES];
	logic [CNTW-1:0] count_q;
	logic [18:0]     total_q;

	// sequencer state
	state_t          state_q;
	pass_t           pass_q;
	logic [SCW-1:0]  cnt_q;
	logic [63:0]     h_q, s_q;
	logic [64:0]     acc_q;
	logic [18:0]     roll_q;
	logic [23:0]     cx_q, cz_q, ax_q, az_q;
	logic [2:0]      sel_q;
	logic            spawn_q;
	logic signed [24:0] px_q, pz_q;

	// output register
	logic            ovalid_q;
	logic [2:0]      ostatus_q, oidx_q;
	logic            ospawn_q;
	logic signed [24:0] opx_q, opz_q;

	logic acc_in, out_free;
	assign out_free = ~ovalid_q | out_ready;
	assign in_ready = (state_q == S_IDLE) & out_free;
	assign acc_in   = in_valid & in_ready;

	// combine value mux
	logic [63:0] mval, mixed;
	logic        mix_last;
	always_comb begin
		mval = GOLDEN;
		mix_last = 1'b0;
		case (pass_q)
			PASS_PICK: begin
				mix_last = (cnt_q == SCW'(4));
				case (cnt_q)
					SCW'(0): mval = {32'd0, selector_q};
					SCW'(1): mval = {59'd0, resolution_q};
					SCW'(2): mval = {32'd0, {{8{cx_q[23]}}, cx_q}};
					SCW'(3): mval = {32'd0, {{8{cz_q[23]}}, cz_q}};
					default: mval = {63'd0, mode_q};
				endcase
			end
			PASS_JX: begin
				mix_last = (cnt_q == SCW'(3));
				case (cnt_q)
					SCW'(0): mval = {32'd0, selector_q};
					SCW'(1): mval = {32'd0, {{8{cx_q[23]}}, cx_q}};
					SCW'(2): mval = {32'd0, {{8{cz_q[23]}}, cz_q}};
					default: mval = {63'd0, mode_q};
				endcase
			end
			default: begin
				mix_last = 1'b1;
				mval = GOLDEN;
			end
		endcase
		mixed = h_q ^ (mval + GOLDEN + (h_q << 6) + (h_q >> 2));
	end

	// shared multiplier operand select
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p, fconst;
	logic [31:0] mh_m;
	logic [64:0] mh_add;
	logic [64:0] mh_acc1;
	logic [13:0] mh_q;
	logic signed [24:0] offset;

	always_comb begin
		fconst = (cnt_q < SCW'(4)) ? FMIX_C1 : FMIX_C2;
		mh_m   = (pass_q == PASS_PICK) ? {13'd0, total_q} : {19'd0, jitter_q, 1'b0};
		mh_add = (pass_q == PASS_PICK) ? 65'd0 : {2'b00, 1'b1, 62'd0} << 1;
		mul_a  = h_q[31:0];
		mul_b  = mh_m;
		if (state_q == S_FMIX) begin
			case (cnt_q)
				SCW'(2), SCW'(6): begin
					mul_a = h_q[63:32];
					mul_b = fconst[31:0];
				end
				SCW'(3), SCW'(7): begin
					mul_a = h_q[31:0];
					mul_b = fconst[63:32];
				end
				default: begin
					mul_a = h_q[31:0];
					mul_b = fconst[31:0];
				end
			endcase
		end else if (state_q == S_MULHI && cnt_q != '0) begin
			mul_a = h_q[63:32];
		end
		mul_p   = mul_a * mul_b;
		mh_acc1 = {32'd0, acc_q[64:32]} + {1'b0, mul_p};
		mh_q    = mh_acc1[45:32];
		offset  = 25'($signed({1'b0, mh_q})) - 25'($signed({1'b0, jitter_q}));
	end

	logic [18:0] rw_rd;
	logic        em_rd, scan_hit;
	assign rw_rd    = rw_q[cnt_q[IDXW-1:0]];
	assign em_rd    = em_q[cnt_q[IDXW-1:0]];
	assign scan_hit = (roll_q < rw_rd) ||
		(CMPW'(cnt_q) == CMPW'(count_q) - CMPW'(1));

	// append check
	logic [19:0] new_total;
	logic        app_ok;
	assign new_total = {1'b0, total_q} + {4'd0, entry_weight};
	assign app_ok = (entry_weight != '0) && (CMPW'(count_q) < CMPW'(MAX_CANDIDATES))
		&& (new_total <= {1'b0, TOTAL_MAX});

	// table storage, no reset
	always_ff @(posedge clk) begin
		if (acc_in && op == OP_APPEND && app_ok) begin
			rw_q[count_q[IDXW-1:0]] <= new_total[18:0];
			em_q[count_q[IDXW-1:0]] <= entry_empty;
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		if (acc_in) begin
			cx_q  <= cell_x;
			cz_q  <= cell_z;
			ax_q  <= anchor_x;
			az_q  <= anchor_z;
			h_q   <= pick_seed_q;
		end
		case (state_q)
			S_MIX: begin
				h_q <= mixed;
				if (mix_last && pass_q == PASS_JX)
					s_q <= mixed;
			end
			S_FMIX: begin
				case (cnt_q)
					SCW'(0), SCW'(4), SCW'(8): h_q <= h_q ^ (h_q >> 33);
					SCW'(1), SCW'(5): acc_q <= {1'b0, mul_p};
					SCW'(2), SCW'(6): acc_q <= acc_q + {1'b0, mul_p[31:0], 32'd0};
					default: h_q <= acc_q[63:0] + {mul_p[31:0], 32'd0};
				endcase
			end
			S_MULHI: begin
				if (cnt_q == '0) begin
					acc_q <= {1'b0, mul_p} + mh_add;
				end else begin
					case (pass_q)
						PASS_PICK: roll_q <= mh_acc1[50:32];
						PASS_JX: begin
							px_q <= $signed({ax_q[23], ax_q}) + offset;
							h_q  <= s_q;
						end
						default: pz_q <= $signed({az_q[23], az_q}) + offset;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					sel_q   <= 3'(cnt_q);
					spawn_q <= ~em_rd;
					px_q    <= $signed({ax_q[23], ax_q});
					pz_q    <= $signed({az_q[23], az_q});
					h_q     <= offset_seed_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= PASS_PICK;
			cnt_q   <= '0;
			count_q <= '0;
			total_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q  <= '0;
					pass_q <= PASS_PICK;
					if (acc_in) begin
						if (op == OP_APPEND && app_ok) begin
							count_q <= count_q + CNTW'(1);
							total_q <= new_total[18:0];
						end else if (op == OP_CLEAR) begin
							count_q <= '0;
							total_q <= '0;
						end else if (op == OP_QUERY && count_q != '0 && total_q != '0) begin
							state_q <= S_MIX;
						end
					end
				end
				S_MIX: begin
					cnt_q <= mix_last ? '0 : cnt_q + SCW'(1);
					if (mix_last)
						state_q <= S_FMIX;
				end
				S_FMIX: begin
					cnt_q <= (cnt_q == SCW'(8)) ? '0 : cnt_q + SCW'(1);
					if (cnt_q == SCW'(8))
						state_q <= S_MULHI;
				end
				S_MULHI: begin
					cnt_q <= (cnt_q == '0) ? SCW'(1) : '0;
					if (cnt_q != '0) begin
						case (pass_q)
							PASS_PICK: state_q <= S_SCAN;
							PASS_JX: begin
								pass_q  <= PASS_JZ;
								state_q <= S_MIX;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_SCAN: begin
					cnt_q <= scan_hit ? '0 : cnt_q + SCW'(1);
					if (scan_hit) begin
						if (jitter_q == '0) begin
							state_q <= S_OUT;
						end else begin
							pass_q  <= PASS_JX;
							state_q <= S_MIX;
						end
					end
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (acc_in && !(op == OP_QUERY && count_q != '0 && total_q != '0)) begin
			ovalid_q <= 1'b1;
		end else if (state_q == S_OUT && out_free) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			oidx_q   <= '0;
			ospawn_q <= 1'b0;
			opx_q    <= '0;
			opz_q    <= '0;
			case (op)
				OP_APPEND: ostatus_q <= app_ok ? ST_APPENDED : ST_REJECTED;
				OP_CLEAR:  ostatus_q <= ST_CLEARED;
				OP_QUERY:  ostatus_q <= ST_NONE;
				default:   ostatus_q <= ST_REJECTED;
			endcase
		end else if (state_q == S_OUT && out_free) begin
			ostatus_q <= ST_PICKED;
			oidx_q    <= sel_q;
			ospawn_q  <= spawn_q;
			opx_q     <= px_q;
			opz_q     <= pz_q;
		end
	end

	assign out_valid    = ovalid_q;
	assign status       = ostatus_q;
	assign chosen_index = oidx_q;
	assign spawn_flag   = ospawn_q;
	assign place_x      = opx_q;
	assign place_z      = opz_q;
endmodule
`default_nettype wire

[rtl/core/hwp_checker.sv]
// ----------------------------------------------------------------------------
// hwp_checker
// Port-level checks of the weighted picker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hashed_weighted_pick_with_jitter_top_macros.svh"
module hwp_checker
	import hwp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  status,
	input wire logic [2:0]  chosen_index,
	input wire logic        spawn_flag,
	input wire logic [24:0] place_x,
	input wire logic [24:0] place_z
);
	`HWP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(status), "stalled result changed")
	`HWP_ASSERT_NOW(a_code, out_valid, status == ST_PICKED || status == ST_APPENDED || status == ST_REJECTED || status == ST_NONE || status == ST_CLEARED, "bad status")
	`HWP_ASSERT_NOW(a_zero, out_valid && status != ST_PICKED, chosen_index == 3'd0 && !spawn_flag && place_x == 25'd0 && place_z == 25'd0, "nonzero fields")
	`HWP_ASSERT_NEXT(a_busy, in_valid && in_ready, out_valid || !in_ready, "transfer lost")
endmodule

bind hashed_weighted_pick_with_jitter_top hwp_checker u_hwp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.chosen_index(chosen_index), .spawn_flag(spawn_flag),
	.place_x(place_x), .place_z(place_z)
);
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for hashed_weighted_pick_with_jitter_top
// Drives append, clear, query and undefined-op transfers with random idling
// on both sides, predicts every result from its own copy of the table and
// registers, and checks each result transfer field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Candidate table model plus an in-order store of the results it predicts.
class pick_scoreboard;
	logic [63:0] pick_seed, offset_seed;
	logic [11:0] jitter_limit;
	logic [31:0] selector_number;
	logic [4:0]  resolution_level;
	logic        placement_mode;
	logic [18:0] sums [8];
	logic        nulls [8];
	int unsigned fill;
	logic [18:0] total;
	logic [56:0] pending [$];   // {status, index, spawn, x, z}
	int unsigned mismatches;

	function new();
		pick_seed = 0; offset_seed = 0; jitter_limit = 0;
		selector_number = 1; resolution_level = 0; placement_mode = 0;
		fill = 0; total = 0; mismatches = 0;
	endfunction

	function logic [63:0] mix_in(logic [63:0] s, logic [63:0] v);
		return s ^ (v + hwp_pkg::GOLDEN + (s << 6) + (s >> 2));
	endfunction

	function logic [63:0] avalanche(logic [63:0] v);
		v ^= v >> 33;
		v = v * hwp_pkg::FMIX_C1;
		v ^= v >> 33;
		v = v * hwp_pkg::FMIX_C2;
		v ^= v >> 33;
		return v;
	endfunction

	// floor((h*m + add) / 2^64)
	function logic [63:0] scale_high(logic [63:0] h, logic [31:0] m, logic [63:0] add);
		logic [127:0] p;
		p = {64'd0, h} * {96'd0, m} + {64'd0, add};
		return p[127:64];
	endfunction

	function logic signed [24:0] shift_axis(logic signed [24:0] a, logic [63:0] h);
		logic [63:0] q;
		q = scale_high(h, {19'd0, jitter_limit, 1'b0}, 64'h8000000000000000);
		return a + 25'(q) - 25'(jitter_limit);
	endfunction

	function void note_input(logic [1:0] op, logic signed [23:0] cx, logic signed [23:0] cz,
			logic signed [23:0] ax, logic signed [23:0] az, logic [15:0] w, logic e);
		logic [2:0] st, idx;
		logic spawn;
		logic signed [24:0] px, pz;
		logic [63:0] h, s, roll, vx, vz;
		int sel;
		st = hwp_pkg::ST_REJECTED; idx = 0; spawn = 0; px = 0; pz = 0;
		if (op == hwp_pkg::OP_APPEND) begin
			if (w != 0 && fill < 8 && {1'b0, total} + w <= hwp_pkg::TOTAL_MAX) begin
				total = 19'({1'b0, total} + w);
				sums[fill] = total;
				nulls[fill] = e;
				fill++;
				st = hwp_pkg::ST_APPENDED;
			end
		end else if (op == hwp_pkg::OP_CLEAR) begin
			fill = 0; total = 0; st = hwp_pkg::ST_CLEARED;
		end else if (op == hwp_pkg::OP_QUERY) begin
			if (fill == 0 || total == 0) begin
				st = hwp_pkg::ST_NONE;
			end else begin
				vx = {32'd0, 32'(cx)};
				vz = {32'd0, 32'(cz)};
				h = mix_in(pick_seed, {32'd0, selector_number});
				h = mix_in(h, {59'd0, resolution_level});
				h = mix_in(mix_in(h, vx), vz);
				h = mix_in(h, {63'd0, placement_mode});
				roll = scale_high(avalanche(h), {13'd0, total}, 0);
				sel = fill - 1;
				for (int i = 0; i < fill; i++)
					if (roll < sums[i]) begin
						sel = i;
						break;
					end
				px = 25'(ax); pz = 25'(az);
				if (jitter_limit != 0) begin
					s = mix_in(offset_seed, {32'd0, selector_number});
					s = mix_in(mix_in(s, vx), vz);
					s = mix_in(s, {63'd0, placement_mode});
					px = shift_axis(px, avalanche(s));
					pz = shift_axis(pz, avalanche(mix_in(s, hwp_pkg::GOLDEN)));
				end
				st = hwp_pkg::ST_PICKED;
				idx = 3'(sel);
				spawn = !nulls[sel];
			end
		end
		pending.insert(pending.size(), {st, idx, spawn, px, pz});
	endfunction

	function void check_result(logic [56:0] got);
		logic [56:0] want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: st %0d/%0d idx %0d/%0d spawn %0d/%0d x %h/%h z %h/%h",
					want[56:54], got[56:54], want[53:51], got[53:51], want[50], got[50],
					want[49:25], got[49:25], want[24:0], got[24:0]);
		end
	endfunction
endclass

module tb_top;
	import hwp_pkg::*;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [5:0] paddr = 0;
	logic [63:0] pwdata = 0, prdata;
	logic pready;
	logic in_valid = 0, in_ready;
	logic [1:0] op = 0;
	logic signed [23:0] cell_x = 0, cell_z = 0, anchor_x = 0, anchor_z = 0;
	logic [15:0] entry_weight = 0;
	logic entry_empty = 0;
	logic out_valid, out_ready = 0;
	logic [2:0] status, chosen_index;
	logic spawn_flag;
	logic signed [24:0] place_x, place_z;

	// idle percentages for the sender and the receiver; hold counts a long stall
	int send_idle = 0, recv_idle = 0, hold_cycles = 0;
	pick_scoreboard board;

	hashed_weighted_pick_with_jitter_top dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// Generous: ~1800 items, each with its busy time plus heavy idling.
	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	// Receiver: random stalls, or a counted long hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Every result transfer goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result({status, chosen_index, spawn_flag, place_x, place_z});
	end

	// Register write: setup then access cycle; pready is tied high.
	task automatic write_reg(reg_idx_t r, logic [63:0] v);
		in_valid <= 0;
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= {r, 3'b000}; pwdata <= v; penable <= 0;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (r)
			REG_PICK_SEED:   board.pick_seed = v;
			REG_OFFSET_SEED: board.offset_seed = v;
			REG_JITTER:      board.jitter_limit = v[11:0];
			REG_SELECTOR:    board.selector_number = v[31:0];
			REG_RESOLUTION:  board.resolution_level = v[4:0];
			default:         board.placement_mode = v[0];
		endcase
	endtask

	// One input transfer; valid stays up until the handshake.
	task automatic send(logic [1:0] o, logic signed [23:0] cx, logic signed [23:0] cz,
			logic signed [23:0] ax, logic signed [23:0] az, logic [15:0] w, logic e);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; op <= o; cell_x <= cx; cell_z <= cz;
		anchor_x <= ax; anchor_z <= az; entry_weight <= w; entry_empty <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(o, cx, cz, ax, az, w, e);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic random_item();
		int k;
		logic [15:0] w;
		logic signed [23:0] cx, cz, ax, az;
		logic e;
		k = $urandom_range(99);
		w = ($urandom_range(9) == 0) ? 16'd0 :
			($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
		cx = 24'($urandom); cz = 24'($urandom);
		ax = 24'($urandom); az = 24'($urandom);
		e = 1'($urandom);
		if (k < 60)
			send(OP_QUERY, cx, cz, ax, az, 16'($urandom), e);
		else if (k < 87)
			send(OP_APPEND, cx, cz, ax, az, w, e);
		else if (k < 95)
			send(OP_CLEAR, cx, cz, ax, az, 16'($urandom), e);
		else
			send(2'd3, cx, cz, ax, az, 16'($urandom), e);
	endtask

	initial begin
		int idles [4][2];
		logic signed [23:0] lo, hi;
		idles = '{'{0, 0}, '{82, 0}, '{0, 82}, '{30, 30}};
		board = new();
		lo = 24'sh800000; hi = 24'sh7FFFFF;
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: empty table, rejects, full table, extremes, clear
		send(OP_QUERY, 0, 0, 0, 0, 0, 0);
		send(OP_APPEND, 0, 0, 0, 0, 16'd0, 0);
		send(2'd3, hi, lo, hi, lo, 16'd5, 1);
		for (int i = 0; i < 9; i++)
			send(OP_APPEND, 0, 0, 0, 0, (i == 0) ? 16'd1 : 16'hFFFF, i[0]);
		send(OP_QUERY, lo, hi, lo, hi, 0, 0);
		send(OP_QUERY, hi, lo, hi, lo, 0, 0);
		drain();
		write_reg(REG_JITTER, 64'd2048);
		write_reg(REG_PICK_SEED, 64'hFFFFFFFFFFFFFFFF);
		write_reg(REG_OFFSET_SEED, 64'hFFFFFFFFFFFFFFFF);
		send(OP_QUERY, lo, lo, lo, lo, 16'hFFFF, 1);
		send(OP_QUERY, hi, hi, hi, hi, 16'hFFFF, 1);
		send(OP_QUERY, -1, 1, 0, -1, 0, 0);
		send(OP_CLEAR, 0, 0, 0, 0, 0, 0);
		send(OP_QUERY, 1, 1, 1, 1, 0, 0);
		send(OP_APPEND, 0, 0, 0, 0, 16'd7, 1);
		send(OP_QUERY, 5, 9, 3, 3, 0, 0);
		drain();

		// random phases, each under a new register setting
		for (int ph = 0; ph < 8; ph++) begin
			send_idle = idles[ph % 4][0];
			recv_idle = idles[ph % 4][1];
			write_reg(REG_PICK_SEED, {$urandom, $urandom});
			write_reg(REG_OFFSET_SEED, {$urandom, $urandom});
			write_reg(REG_JITTER, (ph == 0) ? 64'd0 : (ph == 1) ? 64'd2048 :
				(ph == 2) ? 64'd1 : 64'($urandom_range(4095)));
			write_reg(REG_SELECTOR, (ph == 1) ? 64'hFFFFFFFF : (ph == 2) ? 64'd0 : 64'($urandom));
			write_reg(REG_RESOLUTION, (ph == 1) ? 64'd31 : 64'($urandom_range(31)));
			write_reg(REG_MODE, 64'(ph & 1));
			if (ph == 3) hold_cycles = 600;   // long receiver hold-off
			for (int n = 0; n < 220; n++) begin
				random_item();
				if (n == 110) drain();    // sender waits for all results
			end
			drain();
		end

		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
